[hw/rtl/rrwq_pkg.sv]
// Shared types and codes for the resource request wait queue.
package rrwq_pkg;

    localparam logic [1:0] MODE_GET_SYNC    = 2'd0;
    localparam logic [1:0] MODE_GET_ASYNC   = 2'd1;
    localparam logic [1:0] MODE_GET_PARTIAL = 2'd2;
    localparam logic [1:0] MODE_RESUME      = 2'd3;

    localparam logic [2:0] ST_SUCCESS      = 3'd0;
    localparam logic [2:0] ST_PENDING      = 3'd1;
    localparam logic [2:0] ST_NO_RESOURCES = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL   = 3'd3;
    localparam logic [2:0] ST_NOTHING      = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] requested_count;
        logic [15:0] available_count;
        logic [31:0] request_tag;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_count;
        logic [31:0] resume_tag;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] count;
        logic        partial;
        logic [31:0] tag;
    } entry_t;

endpackage

[hw/rtl/resource_request_wait_queue.sv]
// Top level of the resource request wait queue.
// A word accepted from the s_ side is held in the input register, and its result
// is registered in the output register that drives the m_ side.
// Throughput: one word per cycle while the m_ side takes results; the head entry
// and the entry behind it sit in registers, so a pop is followed by the next word with no bubble.
// Reset (aresetn low, synchronous): queue empty, both registers empty.
module resource_request_wait_queue
    import rrwq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_word_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rsp_word_t m_data
);

    localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);

    logic              in_valid_reg;
    req_word_t         in_reg;
    logic              out_valid_reg;
    rsp_word_t         out_reg;
    rsp_word_t         out_next;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    entry_t            hd_reg, hd_next;

    entry_t            second;
    logic              wr_en;
    entry_t            wr_entry;
    logic [SLOT_W-1:0] rd_addr;

    logic              fire;
    logic              q_empty, q_full;
    logic              short_head;
    logic              split_get;
    logic [15:0]       req_left;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign q_empty    = (occ_reg == '0);
    assign q_full     = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign short_head = (hd_reg.count > in_reg.available_count);
    assign split_get  = (in_reg.mode == MODE_GET_PARTIAL) && q_empty;
    assign req_left   = in_reg.requested_count - in_reg.available_count;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        hd_next   = hd_reg;
        wr_en     = 1'b0;
        wr_entry.count   = split_get ? req_left : in_reg.requested_count;
        wr_entry.partial = split_get;
        wr_entry.tag     = in_reg.request_tag;
        out_next  = '{status: ST_SUCCESS, granted_count: '0, resume_tag: '0};

        unique case (in_reg.mode)
            MODE_RESUME: begin
                if (q_empty) begin
                    out_next.status = ST_NOTHING;
                end else begin
                    out_next.resume_tag = hd_reg.tag;
                    if (short_head) begin
                        if (!hd_reg.partial) begin
                            out_next.status = ST_NO_RESOURCES;
                        end else begin
                            out_next.status        = ST_PENDING;
                            out_next.granted_count = in_reg.available_count;
                            hd_next.count = hd_reg.count - in_reg.available_count;
                        end
                    end else begin
                        out_next.status        = ST_SUCCESS;
                        out_next.granted_count = hd_reg.count;
                        head_next = next_slot(head_reg);
                        occ_next  = occ_reg - 1'b1;
                        hd_next   = second;
                    end
                end
            end
            MODE_GET_SYNC, MODE_GET_ASYNC, MODE_GET_PARTIAL: begin
                if (q_empty && (in_reg.requested_count <= in_reg.available_count)) begin
                    out_next.status        = ST_SUCCESS;
                    out_next.granted_count = in_reg.requested_count;
                end else if (in_reg.mode == MODE_GET_SYNC) begin
                    out_next.status = ST_NO_RESOURCES;
                end else if (q_full) begin
                    out_next.status = ST_QUEUE_FULL;
                end else begin
                    out_next.status        = ST_PENDING;
                    out_next.granted_count = split_get ? in_reg.available_count : 16'd0;
                    wr_en     = 1'b1;
                    tail_next = next_slot(tail_reg);
                    occ_next  = occ_reg + 1'b1;
                    if (q_empty) begin
                        hd_next = wr_entry;
                    end
                end
            end
            default: begin
                out_next.status = ST_NOTHING;
            end
        endcase

        if (!fire) begin
            head_next = head_reg;
            tail_next = tail_reg;
            occ_next  = occ_reg;
            hd_next   = hd_reg;
            wr_en     = 1'b0;
        end
    end

    // second holds the entry behind the head; unused while fewer than two queued
    assign rd_addr = next_slot(head_next);

    rrwq_slot_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_slot_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data(wr_entry),
        .rd_addr(rd_addr),
        .rd_data(second)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= out_next;
        end
        hd_reg <= hd_next;
    end

endmodule

[hw/rtl/rrwq_slot_mem.sv]
// Slot store for queued requests: one write port, one registered read port.
module rrwq_slot_mem
    import rrwq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [SLOT_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-through so a word written now is seen on the same address
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/tb.sv]
// Self-checking testbench for the resource request wait queue.
module tb;
    import rrwq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    req_word_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rsp_word_t m_data;

    resource_request_wait_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow of the wait queue
    logic [15:0] wq_count   [DEPTH];
    logic        wq_partial [DEPTH];
    logic [31:0] wq_tag     [DEPTH];
    int          wq_head = 0;
    int          wq_tail = 0;
    int          wq_fill = 0;

    rsp_word_t outcomes_due[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int mismatch_count = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int status_seen[8];

    function automatic rsp_word_t predict_outcome(input req_word_t w);
        rsp_word_t   r;
        logic [15:0] cnt;
        r = '0;
        if (w.mode == MODE_RESUME) begin
            if (wq_fill == 0) begin
                r.status = ST_NOTHING;
            end else begin
                cnt = wq_count[wq_head];
                r.resume_tag = wq_tag[wq_head];
                if (cnt > w.available_count) begin
                    if (!wq_partial[wq_head]) begin
                        r.status = ST_NO_RESOURCES;
                    end else begin
                        wq_count[wq_head] = cnt - w.available_count;
                        r.status = ST_PENDING;
                        r.granted_count = w.available_count;
                    end
                end else begin
                    r.status = ST_SUCCESS;
                    r.granted_count = cnt;
                    wq_head = (wq_head + 1) % DEPTH;
                    wq_fill--;
                end
            end
        end else if (wq_fill == 0 && w.requested_count <= w.available_count) begin
            r.status = ST_SUCCESS;
            r.granted_count = w.requested_count;
        end else if (w.mode == MODE_GET_SYNC) begin
            r.status = ST_NO_RESOURCES;
        end else if (wq_fill == DEPTH) begin
            r.status = ST_QUEUE_FULL;
        end else begin
            if (w.mode == MODE_GET_PARTIAL && wq_fill == 0) begin
                wq_count[wq_tail]   = w.requested_count - w.available_count;
                wq_partial[wq_tail] = 1'b1;
                r.granted_count     = w.available_count;
            end else begin
                wq_count[wq_tail]   = w.requested_count;
                wq_partial[wq_tail] = 1'b0;
            end
            wq_tag[wq_tail] = w.request_tag;
            wq_tail = (wq_tail + 1) % DEPTH;
            wq_fill++;
            r.status = ST_PENDING;
        end
        return r;
    endfunction

    task automatic offer_request(input logic [1:0] mode, input logic [15:0] req,
                                 input logic [15:0] avail, input logic [31:0] tag);
        req_word_t w;
        w.mode            = mode;
        w.requested_count = req;
        w.available_count = avail;
        w.request_tag     = tag;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        outcomes_due.push_back(predict_outcome(w));
        words_sent++;
    endtask

    // receiver: random back-pressure, or a long hold when asked
    always @(posedge aclk) begin
        int stall_left;
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic flag_mismatch(input string what, input longint exp, input longint act);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp, act);
    endtask

    always @(posedge aclk) begin
        rsp_word_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch("unexpected word, status", -1, m_data.status);
            end else begin
                exp = outcomes_due.pop_front();
                words_checked++;
                status_seen[exp.status]++;
                if (m_data.status !== exp.status)
                    flag_mismatch("status", exp.status, m_data.status);
                if (m_data.granted_count !== exp.granted_count)
                    flag_mismatch("granted_count", exp.granted_count, m_data.granted_count);
                if (m_data.resume_tag !== exp.resume_tag)
                    flag_mismatch("resume_tag", exp.resume_tag, m_data.resume_tag);
            end
        end
    end

    function automatic logic [15:0] random_count();
        case ($urandom_range(5))
            0: return 16'($urandom_range(65535));
            1: return 16'hffff;
            2: return 16'h0000;
            default: return 16'($urandom_range(12));
        endcase
    endfunction

    task automatic test_edge_cases();
        offer_request(MODE_RESUME, 16'hffff, 16'hffff, 32'hffff_ffff);  // empty resume
        offer_request(MODE_GET_SYNC, 16'd0, 16'd0, 32'h0);
        offer_request(MODE_GET_SYNC, 16'hffff, 16'hffff, 32'h1234_5678);
        offer_request(MODE_GET_SYNC, 16'hffff, 16'hfffe, 32'h0);
        offer_request(MODE_GET_ASYNC, 16'd1, 16'd0, 32'hffff_ffff);
        offer_request(MODE_GET_ASYNC, 16'd0, 16'hffff, 32'ha5a5_5a5a);
        offer_request(MODE_GET_SYNC, 16'd1, 16'hffff, 32'h0);           // queue not empty
        offer_request(MODE_GET_PARTIAL, 16'd5, 16'hffff, 32'h5a5a_a5a5);
        offer_request(MODE_RESUME, 16'd0, 16'd0, 32'h0);                // stalled head
        offer_request(MODE_RESUME, 16'd0, 16'hffff, 32'h0);
        offer_request(MODE_RESUME, 16'hffff, 16'd0, 32'h0);             // zero count head
        offer_request(MODE_RESUME, 16'd0, 16'd4, 32'h0);
        offer_request(MODE_RESUME, 16'd0, 16'd5, 32'h0);
        offer_request(MODE_GET_PARTIAL, 16'hffff, 16'd1000, 32'hdead_beef);
        offer_request(MODE_RESUME, 16'd0, 16'd0, 32'h0);                // partial, nothing free
        offer_request(MODE_RESUME, 16'd0, 16'd64534, 32'h0);
        offer_request(MODE_RESUME, 16'd0, 16'd1, 32'h0);
        offer_request(MODE_GET_PARTIAL, 16'd7, 16'd7, 32'h0);
        offer_request(MODE_GET_ASYNC, 16'd3, 16'd9, 32'h0);
        offer_request(MODE_RESUME, 16'd0, 16'd0, 32'h0);
    endtask

    // hold off the result side, fill the queue, then overfill and drain
    task automatic test_queue_full();
        hold_req = 300;
        for (int i = 0; i < DEPTH; i++)
            offer_request(MODE_GET_ASYNC, 16'($urandom_range(1, 65535)), 16'd0, $urandom);
        offer_request(MODE_GET_ASYNC, 16'd1, 16'd0, $urandom);
        offer_request(MODE_GET_PARTIAL, 16'd9, 16'd3, $urandom);
        offer_request(MODE_GET_SYNC, 16'd0, 16'hffff, $urandom);
        for (int i = 0; i < DEPTH; i++)
            offer_request(MODE_RESUME, 16'($urandom), 16'hffff, $urandom);
    endtask

    task automatic test_random_traffic(input int n_words);
        logic [1:0] mode;
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(99) < 30 + 3 * wq_fill)
                mode = MODE_RESUME;
            else
                mode = 2'($urandom_range(2));
            offer_request(mode, random_count(), random_count(), $urandom);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_idle_pct = 16;
        recv_idle_pct = 66;
        test_edge_cases();
        test_queue_full();
        test_random_traffic(130);

        send_idle_pct = 66;
        recv_idle_pct = 16;
        test_random_traffic(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(130);

        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d requests, checked %0d results, %0d mismatches", words_sent,
                 words_checked, mismatch_count);
        $display("Outcomes: %0d granted, %0d pending, %0d short, %0d full, %0d empty resume",
                 status_seen[ST_SUCCESS], status_seen[ST_PENDING],
                 status_seen[ST_NO_RESOURCES], status_seen[ST_QUEUE_FULL],
                 status_seen[ST_NOTHING]);
        if (mismatch_count == 0 && outcomes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #200us;
        $display("Some tests failed");
        $finish;
    end

endmodule
